// ----- hw/rtl/cpdp_pkg.sv -----
// shared constants, types and slot helpers for the coloring dp step unit
package cpdp_pkg;

   localparam int BAG_SLOTS  = 12;
   localparam int LABEL_BITS = 4;
   localparam int COLOR_W    = BAG_SLOTS * LABEL_BITS;
   localparam int SLOT_W     = 4;
   localparam int KIND_W     = 2;
   localparam int CNT_W      = LABEL_BITS + 1;
   localparam int LABEL_MAX  = (1 << LABEL_BITS) - 1;

   localparam logic [KIND_W-1:0] KIND_INTRO_VERTEX = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INTRO_EDGE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FORGET       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_JOIN         = 2'd3;

   localparam logic [3:0] MAX_COLORS_RESET = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CANON_A,
      ST_CANON_B,
      ST_DISPATCH,
      ST_BASE,
      ST_NEXT,
      ST_INTRO,
      ST_FORGET
   } cpdp_state_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] count;
   } cpdp_canon_stat_type;

   // label of one slot, zero for slots outside the bag
   function automatic logic [LABEL_BITS-1:0] label_at(input logic [COLOR_W-1:0] c,
                                                      input logic [SLOT_W-1:0]  slot);
      logic [LABEL_BITS-1:0] lab;
      lab = '0;
      for (int s = 0; s < BAG_SLOTS; s++) begin
         if (slot == SLOT_W'(s)) begin
            lab = c[s*LABEL_BITS +: LABEL_BITS];
         end
      end
      return lab;
   endfunction

   // overwrite the label of one slot
   function automatic logic [COLOR_W-1:0] put_label(input logic [COLOR_W-1:0]    c,
                                                    input logic [SLOT_W-1:0]     slot,
                                                    input logic [LABEL_BITS-1:0] lab);
      logic [COLOR_W-1:0] r;
      r = c;
      for (int s = 0; s < BAG_SLOTS; s++) begin
         if (slot == SLOT_W'(s)) begin
            r[s*LABEL_BITS +: LABEL_BITS] = lab;
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/cpdp_if.sv -----
// handshake channels of the coloring dp step unit
interface cpdp_req_if
   import cpdp_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [SLOT_W-1:0]     vertex_a;
   logic [SLOT_W-1:0]     vertex_b;
   logic [COLOR_W-1:0]    coloring_a;
   logic [COLOR_W-1:0]    coloring_b;

   modport source (output valid, kind, vertex_a, vertex_b, coloring_a, coloring_b,
                   input ready);
   modport sink (input valid, kind, vertex_a, vertex_b, coloring_a, coloring_b,
                 output ready);
endinterface

interface cpdp_rsp_if
   import cpdp_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [COLOR_W-1:0]    coloring_out;
   logic                  is_valid;
   logic                  last;

   modport source (output valid, coloring_out, is_valid, last, input ready);
   modport sink (input valid, coloring_out, is_valid, last, output ready);
endinterface

interface cpdp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] max_colors;

   modport source (output valid, max_colors, input ready);
   modport sink (input valid, max_colors, output ready);
endinterface

// ----- hw/rtl/cpdp_canon.sv -----
// slot-serial canonical relabeling unit, one slot per cycle
module cpdp_canon
   import cpdp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [COLOR_W-1:0]  word,
   output logic [COLOR_W-1:0]  result,
   output cpdp_canon_stat_type stat
);

   localparam int SCNT_W = $clog2(BAG_SLOTS);
   localparam logic [SCNT_W-1:0] SLOT_LAST = SCNT_W'(BAG_SLOTS - 1);

   logic [COLOR_W-1:0]    src_ff, src_in;
   logic [COLOR_W-1:0]    res_ff, res_in;
   logic [SCNT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      next_ff, next_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [LABEL_BITS-1:0] map_ff [1 << LABEL_BITS];

   logic [LABEL_BITS-1:0] lab;
   logic [LABEL_BITS-1:0] mapped;
   logic [LABEL_BITS-1:0] new_lab;
   logic                  map_clr;
   logic                  map_we;

   always_comb begin
      lab     = src_ff[LABEL_BITS-1:0];
      mapped  = map_ff[lab];
      new_lab = '0;
      if (lab != '0) begin
         new_lab = (mapped == '0) ? next_ff[LABEL_BITS-1:0] : mapped;
      end
      src_in  = src_ff;
      res_in  = res_ff;
      slot_in = slot_ff;
      next_in = next_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      map_clr = 1'b0;
      map_we  = 1'b0;
      if (start) begin
         src_in  = word;
         res_in  = '0;
         slot_in = '0;
         next_in = CNT_W'(1);
         busy_in = 1'b1;
         done_in = 1'b0;
         map_clr = 1'b1;
      end else if (busy_ff) begin
         src_in = src_ff >> LABEL_BITS;
         res_in = {new_lab, res_ff[COLOR_W-1:LABEL_BITS]};
         if (lab != '0 && mapped == '0) begin
            map_we  = 1'b1;
            next_in = next_ff + CNT_W'(1);
         end
         if (slot_ff == SLOT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            slot_in = slot_ff + SCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      res_ff  <= res_in;
      slot_ff <= slot_in;
      next_ff <= next_in;
      if (map_clr) begin
         map_ff <= '{default: '0};
      end else if (map_we) begin
         map_ff[lab] <= next_ff[LABEL_BITS-1:0];
      end
   end

   assign result     = res_ff;
   assign stat.busy  = busy_ff;
   assign stat.done  = done_ff;
   assign stat.count = next_ff - CNT_W'(1);

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("canon unit restarted mid-pass");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("canon unit busy and done together");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("canon done without a pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (stat.count <= CNT_W'(BAG_SLOTS)))
      else $error("canon class count out of range");

endmodule

// ----- hw/rtl/coloring_partition_dp_step_unit.sv -----
// top level of the coloring dp step unit: sequencer, output register and csr
// One request at a time. Every coloring that a step uses goes through a
// slot-serial relabeling unit, and introduce vertex runs one pass per result.
// The single relabeling unit is the rate limit. req ready is high only while
// the unit is idle; the last result sits in the output register while the
// next request is taken. max_colors is written through csr (always ready,
// reset 3) and is meant to change only while no request is in flight.
module coloring_partition_dp_step_unit
   import cpdp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   cpdp_req_if.sink   req_if,
   cpdp_rsp_if.source rsp_if,
   cpdp_csr_if.sink   csr_if
);

   cpdp_state_type state_ff, state_in;

   // request fields kept for the whole step
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [SLOT_W-1:0]  va_ff, va_in;
   logic [SLOT_W-1:0]  vb_ff, vb_in;
   logic [COLOR_W-1:0] cb_ff, cb_in;
   // canonical first coloring, and the base coloring for introduce vertex
   logic [COLOR_W-1:0] ca_ff, ca_in;
   logic [COLOR_W-1:0] base_ff, base_in;
   // class being tried and number of results for introduce vertex
   logic [CNT_W-1:0]   cls_ff, cls_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;

   logic [3:0]         max_colors_ff, max_colors_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_col_ff, rsp_col_in;
   logic               rsp_isv_ff, rsp_isv_in;
   logic               rsp_last_ff, rsp_last_in;

   // relabeling unit
   logic                canon_start;
   logic [COLOR_W-1:0]  canon_word;
   logic [COLOR_W-1:0]  canon_res;
   cpdp_canon_stat_type canon_stat;

   logic                  out_free;
   logic                  emit;
   logic [COLOR_W-1:0]    emit_col;
   logic                  emit_isv;
   logic                  emit_last;
   logic [LABEL_BITS-1:0] lab_a;
   logic [LABEL_BITS-1:0] lab_b;
   logic [CNT_W-1:0]      keff;
   logic                  new_ok;

   cpdp_canon u_canon (
      .clock  (clock),
      .reset  (reset),
      .start  (canon_start),
      .word   (canon_word),
      .result (canon_res),
      .stat   (canon_stat)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign lab_a    = label_at(ca_ff, va_ff);
   assign lab_b    = label_at(ca_ff, vb_ff);

   // k clamped to the bag size; a new class also needs a free label code
   assign keff   = (CNT_W'(max_colors_ff) > CNT_W'(BAG_SLOTS)) ? CNT_W'(BAG_SLOTS)
                                                               : CNT_W'(max_colors_ff);
   assign new_ok = (canon_stat.count < keff) && (canon_stat.count < CNT_W'(LABEL_MAX));

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      cb_in       = cb_ff;
      ca_in       = ca_ff;
      base_in     = base_ff;
      cls_in      = cls_ff;
      limit_in    = limit_ff;
      canon_start = 1'b0;
      canon_word  = req_if.coloring_a;
      emit        = 1'b0;
      emit_col    = '0;
      emit_isv    = 1'b0;
      emit_last   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               kind_in     = req_if.kind;
               va_in       = req_if.vertex_a;
               vb_in       = req_if.vertex_b;
               cb_in       = req_if.coloring_b;
               canon_start = 1'b1;
               canon_word  = req_if.coloring_a;
               state_in    = ST_CANON_A;
            end
         end
         ST_CANON_A: begin
            if (canon_stat.done) begin
               ca_in = canon_res;
               if (kind_ff == KIND_JOIN) begin
                  canon_start = 1'b1;
                  canon_word  = cb_ff;
                  state_in    = ST_CANON_B;
               end else begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         ST_CANON_B: begin
            // join passes only when both partitions match
            if (canon_stat.done && out_free) begin
               emit = 1'b1;
               if (canon_res == ca_ff) begin
                  emit_col = ca_ff;
                  emit_isv = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_DISPATCH: begin
            unique case (kind_ff)
               KIND_INTRO_VERTEX: begin
                  if (va_ff < SLOT_W'(BAG_SLOTS)) begin
                     // clear the slot first, then count the classes left
                     canon_start = 1'b1;
                     canon_word  = put_label(ca_ff, va_ff, '0);
                     state_in    = ST_BASE;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               KIND_INTRO_EDGE: begin
                  // ends in one class (also both absent) reject
                  if (out_free) begin
                     emit = 1'b1;
                     if (lab_a != lab_b) begin
                        emit_col = ca_ff;
                        emit_isv = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end
               KIND_FORGET: begin
                  if (lab_a != '0) begin
                     canon_start = 1'b1;
                     canon_word  = put_label(ca_ff, va_ff, '0);
                     state_in    = ST_FORGET;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               KIND_JOIN: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_BASE: begin
            // classes 1..cnt, plus class cnt+1 when a new one is allowed
            if (canon_stat.done) begin
               base_in  = canon_res;
               limit_in = canon_stat.count + CNT_W'(new_ok);
               cls_in   = CNT_W'(1);
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (limit_ff == '0) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               canon_start = 1'b1;
               canon_word  = put_label(base_ff, va_ff, cls_ff[LABEL_BITS-1:0]);
               state_in    = ST_INTRO;
            end
         end
         ST_INTRO: begin
            if (canon_stat.done && out_free) begin
               emit      = 1'b1;
               emit_col  = canon_res;
               emit_isv  = 1'b1;
               emit_last = (cls_ff == limit_ff);
               if (cls_ff == limit_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cls_in   = cls_ff + CNT_W'(1);
                  state_in = ST_NEXT;
               end
            end
         end
         ST_FORGET: begin
            if (canon_stat.done && out_free) begin
               emit     = 1'b1;
               emit_col = canon_res;
               emit_isv = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_isv_in   = rsp_isv_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = emit_col;
         rsp_isv_in   = emit_isv;
         rsp_last_in  = emit_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // csr write
   always_comb begin
      max_colors_in = max_colors_ff;
      if (csr_if.valid) begin
         max_colors_in = csr_if.max_colors;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_colors_ff <= MAX_COLORS_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_colors_ff <= max_colors_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      cb_ff       <= cb_in;
      ca_ff       <= ca_in;
      base_ff     <= base_in;
      cls_ff      <= cls_in;
      limit_ff    <= limit_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_isv_ff  <= rsp_isv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.coloring_out = rsp_col_ff;
   assign rsp_if.is_valid     = rsp_isv_ff;
   assign rsp_if.last         = rsp_last_ff;

   a_idle_canon_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !canon_stat.busy)
      else $error("request taken while relabeling runs");

   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.is_valid) |-> (rsp_if.last && rsp_if.coloring_out == '0))
      else $error("rejection result malformed");

   a_cls_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INTRO) |-> (cls_ff != '0 && cls_ff <= limit_ff))
      else $error("class index outside result range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten before taken");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the coloring dp step unit: queued requests, own predictor, checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cpdp_pkg::*;

   // quiet cycles without any accepted transfer before giving up
   localparam int STALL_LIMIT  = 2000;
   // settle time at the end, longer than the slowest introduce vertex
   localparam int SETTLE_CYCLES = 250;
   localparam int MAX_PRINTS    = 40;
   localparam int RESULT_CAP    = 12;

   // one dp step request as it goes onto the req channel
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  vertex_a;
      logic [SLOT_W-1:0]  vertex_b;
      logic [COLOR_W-1:0] coloring_a;
      logic [COLOR_W-1:0] coloring_b;
   } dp_step_t;

   // one colouring as it should come out of the rsp channel
   typedef struct packed {
      logic [COLOR_W-1:0] coloring;
      logic               is_valid;
      logic               last;
   } dp_result_t;

   logic clock = 1'b0;
   logic reset;

   cpdp_req_if req_ch ();
   cpdp_rsp_if rsp_ch ();
   cpdp_csr_if csr_ch ();

   coloring_partition_dp_step_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // pending requests for the driver and colourings still owed by the unit
   dp_step_t   pending_steps[$];
   dp_result_t expected_colorings[$];

   // our own copy of the max_colors register, tracked from csr writes
   logic [3:0] k_model = MAX_COLORS_RESET;
   bit         req_took = 1'b0;

   int steps_queued   = 0;
   int steps_taken    = 0;
   int results_seen   = 0;
   int rejects_seen   = 0;
   int settings_used  = 0;
   int fail_count     = 0;
   int print_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // partition arithmetic
   // ---------------------------------------------------------------------------

   // label of one slot; slots past the bag read as absent
   function automatic logic [LABEL_BITS-1:0] slot_label(input logic [COLOR_W-1:0] c,
                                                        input int slot);
      if (slot >= BAG_SLOTS) return '0;
      return c[slot*LABEL_BITS +: LABEL_BITS];
   endfunction

   function automatic logic [COLOR_W-1:0] set_slot(input logic [COLOR_W-1:0]    c,
                                                   input int                    slot,
                                                   input logic [LABEL_BITS-1:0] lab);
      logic [COLOR_W-1:0] r;
      r = c;
      if (slot < BAG_SLOTS) r[slot*LABEL_BITS +: LABEL_BITS] = lab;
      return r;
   endfunction

   // renumber classes 1, 2, ... in order of first appearance by slot
   function automatic logic [COLOR_W-1:0] renumber_classes(input  logic [COLOR_W-1:0] c,
                                                           output int classes);
      logic [LABEL_BITS-1:0] remap [0:LABEL_MAX];
      logic [LABEL_BITS-1:0] lab;
      logic [COLOR_W-1:0]    r;
      int                    next_label;
      r = '0;
      next_label = 1;
      for (int i = 0; i <= LABEL_MAX; i++) remap[i] = '0;
      for (int s = 0; s < BAG_SLOTS; s++) begin
         lab = c[s*LABEL_BITS +: LABEL_BITS];
         if (lab != '0) begin
            if (remap[lab] == '0) begin
               remap[lab] = LABEL_BITS'(next_label);
               next_label++;
            end
            r[s*LABEL_BITS +: LABEL_BITS] = remap[lab];
         end
      end
      classes = next_label - 1;
      return r;
   endfunction

   function automatic logic [COLOR_W-1:0] canonical(input logic [COLOR_W-1:0] c);
      int unused;
      return renumber_classes(c, unused);
   endfunction

   // ---------------------------------------------------------------------------
   // predictor: expected colourings of one accepted request
   // ---------------------------------------------------------------------------
   function automatic void predict_step(input dp_step_t st, input logic [3:0] k);
      logic [COLOR_W-1:0] ca, cb, base;
      dp_result_t         outs[$];
      int                 na, nb, cnt, k_eff, va;
      ca = renumber_classes(st.coloring_a, na);
      cb = renumber_classes(st.coloring_b, nb);
      va = int'(st.vertex_a);
      case (st.kind)
         KIND_INTRO_VERTEX: begin
            if (va < BAG_SLOTS) begin
               // k above the bag size behaves as the bag size
               k_eff = (int'(k) > BAG_SLOTS) ? BAG_SLOTS : int'(k);
               // a present slot is taken out first, then placed again
               base = renumber_classes(set_slot(ca, va, '0), cnt);
               // join every existing class, then the fresh class if allowed
               for (int cls = 1; cls <= cnt; cls++) begin
                  outs.push_back('{canonical(set_slot(base, va, LABEL_BITS'(cls))),
                                   1'b1, 1'b0});
               end
               if (cnt < k_eff && cnt < LABEL_MAX) begin
                  outs.push_back('{canonical(set_slot(base, va, LABEL_BITS'(cnt + 1))),
                                   1'b1, 1'b0});
               end
            end
         end
         KIND_INTRO_EDGE: begin
            // both ends in one class, the empty one included, kills it
            if (slot_label(ca, va) != slot_label(ca, int'(st.vertex_b)))
               outs.push_back('{ca, 1'b1, 1'b0});
         end
         KIND_FORGET: begin
            if (slot_label(ca, va) != '0)
               outs.push_back('{canonical(set_slot(ca, va, '0)), 1'b1, 1'b0});
         end
         default: begin
            if (ca == cb) outs.push_back('{ca, 1'b1, 1'b0});
         end
      endcase
      while (outs.size() > RESULT_CAP) void'(outs.pop_back());
      // nothing survived: one rejection carries the last flag
      if (outs.size() == 0) outs.push_back('{'0, 1'b0, 1'b1});
      else outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_colorings.push_back(outs[i]);
   endfunction

   // ---------------------------------------------------------------------------
   // random request shapes
   // ---------------------------------------------------------------------------
   function automatic logic [COLOR_W-1:0] random_partition(input int fill_pct,
                                                           input int label_span);
      logic [COLOR_W-1:0] c;
      c = '0;
      for (int s = 0; s < BAG_SLOTS; s++) begin
         if ($urandom_range(99) < fill_pct)
            c[s*LABEL_BITS +: LABEL_BITS] = LABEL_BITS'($urandom_range(label_span, 1));
      end
      return c;
   endfunction

   // same partition under a random bijection of the nonzero labels
   function automatic logic [COLOR_W-1:0] scramble_labels(input logic [COLOR_W-1:0] c);
      int                 strides [8] = '{1, 2, 4, 7, 8, 11, 13, 14};
      int                 m, o, lab;
      logic [COLOR_W-1:0] r;
      m = strides[$urandom_range(7)];
      o = $urandom_range(LABEL_MAX - 1);
      r = '0;
      for (int s = 0; s < BAG_SLOTS; s++) begin
         lab = int'(c[s*LABEL_BITS +: LABEL_BITS]);
         if (lab != 0)
            r[s*LABEL_BITS +: LABEL_BITS] = LABEL_BITS'(((lab - 1) * m + o) % LABEL_MAX + 1);
      end
      return r;
   endfunction

   // a slot that holds a vertex, or any bag slot when the colouring is empty
   function automatic int pick_present(input logic [COLOR_W-1:0] c);
      int used[$];
      for (int s = 0; s < BAG_SLOTS; s++) begin
         if (c[s*LABEL_BITS +: LABEL_BITS] != '0) used.push_back(s);
      end
      if (used.size() == 0) return $urandom_range(BAG_SLOTS - 1);
      return used[$urandom_range(used.size() - 1)];
   endfunction

   function automatic dp_step_t random_step();
      dp_step_t           st;
      int                 shape, roll;
      logic [COLOR_W-1:0] c;
      shape = $urandom_range(99);
      // mostly canonical partitions, some relabeled ones and some raw noise
      if (shape < 10) c = COLOR_W'({$urandom(), $urandom()});
      else if (shape < 25)
         c = scramble_labels(random_partition($urandom_range(100), $urandom_range(LABEL_MAX, 1)));
      else c = canonical(random_partition($urandom_range(100), $urandom_range(BAG_SLOTS, 1)));
      st.kind       = KIND_W'($urandom_range(3));
      st.vertex_a   = SLOT_W'($urandom_range(15));
      st.vertex_b   = SLOT_W'($urandom_range(15));
      st.coloring_a = c;
      st.coloring_b = COLOR_W'({$urandom(), $urandom()});
      roll = $urandom_range(99);
      case (st.kind)
         KIND_INTRO_VERTEX: begin
            if (roll >= 15) st.vertex_a = SLOT_W'($urandom_range(BAG_SLOTS - 1));
         end
         KIND_INTRO_EDGE: begin
            st.vertex_a = SLOT_W'(pick_present(c));
            if (roll < 75) st.vertex_b = SLOT_W'(pick_present(c));
            else if (roll < 88) st.vertex_b = st.vertex_a;
         end
         KIND_FORGET: begin
            if (roll < 80) st.vertex_a = SLOT_W'(pick_present(c));
         end
         default: begin
            // joins mostly pair equal partitions so they pass
            if (roll < 40) st.coloring_b = c;
            else if (roll < 70) st.coloring_b = scramble_labels(c);
            else if (roll < 85)
               st.coloring_b = set_slot(c, $urandom_range(BAG_SLOTS - 1),
                                        LABEL_BITS'($urandom_range(3)));
         end
      endcase
      return st;
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: pops pending requests, idles at the sender rate
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin : feed_requests
      dp_step_t next_step;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_step = pending_steps.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.kind       <= next_step.kind;
            req_ch.vertex_a   <= next_step.vertex_a;
            req_ch.vertex_b   <= next_step.vertex_b;
            req_ch.coloring_a <= next_step.coloring_a;
            req_ch.coloring_b <= next_step.coloring_b;
         end else begin
            // idle cycle, payload is don't care so keep it moving
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_W'($urandom_range(3));
            req_ch.vertex_a   <= SLOT_W'($urandom_range(15));
            req_ch.vertex_b   <= SLOT_W'($urandom_range(15));
            req_ch.coloring_a <= COLOR_W'({$urandom(), $urandom()});
            req_ch.coloring_b <= COLOR_W'({$urandom(), $urandom()});
         end
      end
   end

   // result receiver: stalls at the receiver rate
   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // monitor: tracks csr writes, predicts on each request, checks each result
   // ---------------------------------------------------------------------------
   task automatic flag_mismatch(input string msg);
      fail_count++;
      if (print_count < MAX_PRINTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
         print_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      dp_step_t   seen;
      dp_result_t want;
      req_took <= req_ch.valid && req_ch.ready;
      if (reset) begin
         k_model = MAX_COLORS_RESET;
      end else begin
         if (csr_ch.valid && csr_ch.ready) k_model = csr_ch.max_colors;
         // predict first so a result at the same edge still finds older entries
         if (req_ch.valid && req_ch.ready) begin
            seen.kind       = req_ch.kind;
            seen.vertex_a   = req_ch.vertex_a;
            seen.vertex_b   = req_ch.vertex_b;
            seen.coloring_a = req_ch.coloring_a;
            seen.coloring_b = req_ch.coloring_b;
            predict_step(seen, k_model);
            steps_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.is_valid === 1'b0) rejects_seen++;
            if (expected_colorings.size() == 0) begin
               flag_mismatch($sformatf("result %h with nothing outstanding",
                                       rsp_ch.coloring_out));
            end else begin
               want = expected_colorings.pop_front();
               if (rsp_ch.coloring_out !== want.coloring)
                  flag_mismatch($sformatf("coloring_out %h, want %h",
                                          rsp_ch.coloring_out, want.coloring));
               if (rsp_ch.is_valid !== want.is_valid)
                  flag_mismatch($sformatf("is_valid %b, want %b on %h",
                                          rsp_ch.is_valid, want.is_valid, want.coloring));
               if (rsp_ch.last !== want.last)
                  flag_mismatch($sformatf("last %b, want %b on %h",
                                          rsp_ch.last, want.last, want.coloring));
            end
         end
      end
   end

   // watchdog: ends a run that stops moving
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus sequencing
   // ---------------------------------------------------------------------------
   task automatic queue_step(input logic [KIND_W-1:0]  kind,
                             input logic [SLOT_W-1:0]  va,
                             input logic [SLOT_W-1:0]  vb,
                             input logic [COLOR_W-1:0] ca,
                             input logic [COLOR_W-1:0] cb);
      pending_steps.push_back('{kind, va, vb, ca, cb});
      steps_queued++;
   endtask

   // every request taken and every result back: the unit is idle
   task automatic wait_idle();
      do @(negedge clock);
      while (steps_taken != steps_queued || expected_colorings.size() != 0);
   endtask

   // csr write, only issued while the unit is idle
   task automatic set_max_colors(input logic [3:0] k);
      @(negedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.max_colors <= k;
      do @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) pending_steps.push_back(random_step());
      steps_queued += count;
      wait_idle();
   endtask

   initial begin : run_test
      // every input known from time zero
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = KIND_INTRO_VERTEX;
      req_ch.vertex_a   = '0;
      req_ch.vertex_b   = '0;
      req_ch.coloring_a = '0;
      req_ch.coloring_b = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.max_colors = MAX_COLORS_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset value k = 3, no idling
      // introduce vertex: empty colouring, full k, room for a new class
      queue_step(KIND_INTRO_VERTEX, 4'd0, 4'd0, 48'h0, 48'h0);
      queue_step(KIND_INTRO_VERTEX, 4'd11, 4'd0, 48'h000000000321, 48'h0);
      queue_step(KIND_INTRO_VERTEX, 4'd5, 4'd0, 48'h000000000121, 48'h0);
      // slot already present, taken out and placed again
      queue_step(KIND_INTRO_VERTEX, 4'd1, 4'd0, 48'h000000000321, 48'h0);
      // slots past the bag are rejected
      queue_step(KIND_INTRO_VERTEX, 4'd12, 4'd0, 48'h000000000021, 48'h0);
      queue_step(KIND_INTRO_VERTEX, 4'd15, 4'd0, 48'hFFFFFFFFFFFF, 48'h0);
      // non-canonical labels get renumbered first
      queue_step(KIND_INTRO_VERTEX, 4'd0, 4'd0, 48'h90000000F0A0, 48'h0);
      queue_step(KIND_INTRO_VERTEX, 4'd4, 4'd0, 48'hFFFFFFFFFFFF, 48'h0);
      // introduce edge: different classes, same class, equal ends,
      // both absent, one absent, one end past the bag
      queue_step(KIND_INTRO_EDGE, 4'd0, 4'd1, 48'h000000000021, 48'h0);
      queue_step(KIND_INTRO_EDGE, 4'd0, 4'd2, 48'h000000000121, 48'h0);
      queue_step(KIND_INTRO_EDGE, 4'd3, 4'd3, 48'h000000001321, 48'h0);
      queue_step(KIND_INTRO_EDGE, 4'd8, 4'd9, 48'h000000000021, 48'h0);
      queue_step(KIND_INTRO_EDGE, 4'd0, 4'd7, 48'h000000000021, 48'h0);
      queue_step(KIND_INTRO_EDGE, 4'd1, 4'd15, 48'h000000000021, 48'h0);
      // forget: present slot, absent slot, slot past the bag, all-ones input
      queue_step(KIND_FORGET, 4'd1, 4'd0, 48'h000000000321, 48'h0);
      queue_step(KIND_FORGET, 4'd6, 4'd0, 48'h000000000321, 48'h0);
      queue_step(KIND_FORGET, 4'd13, 4'd0, 48'h000000000321, 48'h0);
      queue_step(KIND_FORGET, 4'd11, 4'd0, 48'hFFFFFFFFFFFF, 48'h0);
      // join: identical, same partition under other labels, different, both empty
      queue_step(KIND_JOIN, 4'd0, 4'd0, 48'h000000000121, 48'h000000000121);
      queue_step(KIND_JOIN, 4'd0, 4'd0, 48'h000000000F7F, 48'h000000000212);
      queue_step(KIND_JOIN, 4'd0, 4'd0, 48'h000000000121, 48'h000000000123);
      queue_step(KIND_JOIN, 4'd0, 4'd0, 48'h0, 48'h0);
      wait_idle();

      // k above the bag acts as the bag: eleven classes plus a new one
      set_max_colors(4'd15);
      queue_step(KIND_INTRO_VERTEX, 4'd11, 4'd0, 48'h0BA987654321, 48'h0);
      queue_step(KIND_INTRO_VERTEX, 4'd0, 4'd0, 48'hBA9876543210, 48'h0);
      wait_idle();

      // k = 0 allows no new class: nothing to join in an empty colouring
      set_max_colors(4'd0);
      queue_step(KIND_INTRO_VERTEX, 4'd0, 4'd0, 48'h0, 48'h0);
      wait_idle();

      // random phases, one k and one idling mix each
      set_max_colors(4'd12);
      run_random(70, 0, 0);
      set_max_colors(4'd1);
      run_random(60, 61, 0);
      set_max_colors(4'd0);
      run_random(50, 0, 61);
      set_max_colors(4'd15);
      run_random(70, 14, 14);
      set_max_colors(4'($urandom_range(11, 2)));
      run_random(60, 0, 0);

      // let any stray result show up
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests of all four steps across %0d max_colors settings",
               steps_taken, settings_used);
      $display("and four idling mixes; %0d results checked, %0d of them rejections",
               results_seen, rejects_seen);
      if (fail_count == 0 && expected_colorings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
